// ===== src/bqc_pkg.sv =====
package bqc_pkg;

  // Default configuration of the cascade.
  localparam int SECTIONS_DEF       = 4;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;

  // Fixed widths of the datapath.
  localparam int COEF_W  = 32;  // Q4.x coefficient
  localparam int VAL_W   = 40;  // Q32.8 internal value
  localparam int OUT_W   = 32;  // Q24.8 result
  localparam int HALF_W  = 20;  // value is multiplied in two halves of this width
  localparam int OPB_W   = HALF_W + 1;
  localparam int SUM_W   = COEF_W + 2;  // sum of three coefficients, or 1 plus two
  localparam int PROD_W  = SUM_W + OPB_W;
  localparam int ACC_W   = 76;  // holds five full products plus the rounding half
  localparam int DCNT_W  = $clog2(ACC_W + 1);
  localparam int IDXC_W  = 6;   // wide enough to compare an index against 5*SECTIONS

  // Input operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Coefficient slots inside one section.
  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

  // Last value of the step counter in each phase.
  localparam logic [3:0] K_SUM_LAST  = 4'd4;
  localparam logic [3:0] K_PMUL_LAST = 4'd1;
  localparam logic [3:0] K_MAC_LAST  = 4'd9;

  // Saturate an accumulator-wide value to the internal value width.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-VAL_W:0] top;
    top = a[ACC_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      return a[VAL_W-1:0];
    end
    return a[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // Saturate an internal value to the result width.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] a);
    logic [VAL_W-OUT_W:0] top;
    top = a[VAL_W-1:OUT_W-1];
    if ((&top) || !(|top)) begin
      return a[OUT_W-1:0];
    end
    return a[VAL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

endpackage

// ===== src/biquad_cascade_dc_primed.sv =====
// Cascade of SECTIONS direct form 1 biquads in fixed point. A sample transfer
// (op 0) returns one result; a coefficient transfer (op 1) with an in-range
// index writes one Q4.x coefficient, returns nothing and marks the filter as
// unprimed. All multiplications run on one 34 x 21 bit multiplier feeding a 76 bit
// accumulator, so each section forms ten half-width products, drains the
// pipeline and rounds. The first filtered sample after reset or a coefficient
// write first settles every section at its DC level using a sum of its
// coefficients, one product and a bit-serial division of 76 steps. With
// filter_enable low a sample passes through unfiltered. The block takes a new
// transfer only when the previous one is finished, while a result may still
// wait in the output register.
module biquad_cascade_dc_primed
  import bqc_pkg::*;
#(
  parameter int SECTIONS       = SECTIONS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [4:0]                    coef_index,
  input  logic signed [COEF_W-1:0]      coef_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       filtered,
  output logic                          bypassed
);

  localparam int NCOEF  = 5 * SECTIONS;
  localparam int ADDR_W = $clog2(NCOEF);
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] DEN_ONE  = SUM_W'(1) <<< COEF_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PSUM, S_PMUL, S_PDRAIN, S_PABS, S_PDIV, S_PFIN,
    S_FMUL, S_FDRAIN, S_FRND, S_DONE
  } state_t;

  state_t state;

  logic filter_enable;
  logic primed;
  logic byp;

  logic [SEC_W-1:0] sec;
  logic [3:0]       k;

  logic signed [VAL_W-1:0] samp_r;
  logic signed [VAL_W-1:0] work;
  logic signed [VAL_W-1:0] xh1 [SECTIONS];
  logic signed [VAL_W-1:0] xh2 [SECTIONS];
  logic signed [VAL_W-1:0] yh1 [SECTIONS];
  logic signed [VAL_W-1:0] yh2 [SECTIONS];

  logic signed [COEF_W-1:0] coef_mem [NCOEF];
  logic signed [COEF_W-1:0] coef_rd;

  // Operand and multiply pipeline.
  logic                    s1_v, s1_mul, s1_num, s1_hi, s1_sub;
  logic [2:0]              s1_slot;
  logic signed [OPB_W-1:0] opb_r;
  logic                    s2_v, s2_hi, s2_sub;
  logic signed [PROD_W-1:0] prod;

  logic signed [ACC_W-1:0] acc;
  logic signed [SUM_W-1:0] num;
  logic signed [SUM_W-1:0] den;

  // Division state.
  logic [SUM_W-1:0]  dmag;
  logic [SUM_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic              qneg;

  logic signed [VAL_W-1:0]  samp_v;
  logic                     idx_ok;
  logic                     in_fire;
  logic [2:0]               term;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [VAL_W-1:0]  opv;
  logic signed [OPB_W-1:0]  opb;
  logic signed [SUM_W-1:0]  opa;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_term;
  logic signed [ACC_W-1:0]  prime_q;
  logic signed [VAL_W-1:0]  prime_out;
  logic signed [VAL_W-1:0]  mac_out;
  logic [SUM_W:0]           rem_sh;
  logic                     div_ge;
  logic [SUM_W:0]           rem_diff;
  logic                     last_sec;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign samp_v  = VAL_W'(sample) <<< 8;
  assign idx_ok  = ({1'b0, coef_index} < IDXC_W'(NCOEF));
  assign wr_addr = ADDR_W'(coef_index);

  assign last_sec = (sec == SEC_W'(SECTIONS - 1));

  // While summing coefficients the counter walks slots; while multiplying,
  // each slot takes two steps, low half first.
  assign term    = (state == S_PSUM) ? k[2:0] : k[3:1];
  assign rd_addr = ADDR_W'({sec, 2'b00}) + ADDR_W'(sec) + ADDR_W'(term);

  always_comb begin
    if (state == S_PMUL) begin
      opv = work;
    end else begin
      case (term)
        TERM_B0: opv = work;
        TERM_B1: opv = xh1[sec];
        TERM_B2: opv = xh2[sec];
        TERM_A1: opv = yh1[sec];
        TERM_A2: opv = yh2[sec];
        default: opv = '0;
      endcase
    end
  end

  assign opb = k[0] ? {opv[VAL_W-1], opv[VAL_W-1:HALF_W]} : {1'b0, opv[HALF_W-1:0]};
  assign opa = s1_num ? num : SUM_W'(coef_rd);

  assign prod_ext = ACC_W'(prod);
  assign acc_term = s2_hi ? (prod_ext <<< HALF_W) : prod_ext;

  assign mac_out   = sat_val((acc + RND_HALF) >>> COEF_FRAC_BITS);
  assign prime_q   = qneg ? -acc : acc;
  assign prime_out = sat_val(prime_q);

  // Restoring division: the dividend shifts out of the accumulator's top while
  // quotient bits shift in at the bottom.
  assign rem_sh   = {rem, acc[ACC_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, dmag});
  assign rem_diff = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (in_fire && (op == OP_COEF) && idx_ok) begin
      coef_mem[wr_addr] <= coef_value;
    end
    coef_rd <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      primed        <= 1'b0;
      filter_enable <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        xh1[i] <= '0;
        xh2[i] <= '0;
        yh1[i] <= '0;
        yh2[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        filter_enable <= cfg_data;
      end

      // In S_DONE the output register is loaded below instead.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      s1_v    <= (state == S_PSUM) || (state == S_PMUL) || (state == S_FMUL);
      s1_mul  <= (state != S_PSUM);
      s1_num  <= (state == S_PMUL);
      s1_hi   <= k[0];
      s1_sub  <= (term >= TERM_A1);
      s1_slot <= term;
      opb_r   <= opb;

      s2_v   <= s1_v && s1_mul;
      s2_hi  <= s1_hi;
      s2_sub <= s1_sub;
      prod   <= opa * opb_r;

      if (s1_v && !s1_mul) begin
        if (s1_slot < TERM_A1) begin
          num <= num + SUM_W'(coef_rd);
        end else begin
          den <= den + SUM_W'(coef_rd);
        end
      end

      if (s2_v) begin
        acc <= s2_sub ? (acc - acc_term) : (acc + acc_term);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (op == OP_COEF) begin
              primed <= primed && !idx_ok;
            end else if (!filter_enable) begin
              work  <= samp_v;
              byp   <= 1'b1;
              state <= S_DONE;
            end else begin
              samp_r <= samp_v;
              work   <= samp_v;
              byp    <= 1'b0;
              sec    <= '0;
              k      <= '0;
              acc    <= '0;
              num    <= '0;
              den    <= DEN_ONE;
              state  <= primed ? S_FMUL : S_PSUM;
            end
          end
        end
        S_PSUM: begin
          if (k == K_SUM_LAST) begin
            k     <= '0;
            state <= S_PMUL;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_PMUL: begin
          if (k == K_PMUL_LAST) begin
            k     <= '0;
            state <= S_PDRAIN;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_PDRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= S_PABS;
          end
        end
        S_PABS: begin
          // A section whose denominator vanishes settles at zero.
          if (den == '0) begin
            acc   <= '0;
            qneg  <= 1'b0;
            state <= S_PFIN;
          end else begin
            qneg  <= acc[ACC_W-1] ^ den[SUM_W-1];
            acc   <= acc[ACC_W-1] ? -acc : acc;
            dmag  <= den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
            rem   <= '0;
            dcnt  <= DCNT_W'(ACC_W);
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          rem  <= div_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
          acc  <= {acc[ACC_W-2:0], div_ge};
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) begin
            state <= S_PFIN;
          end
        end
        S_PFIN: begin
          xh1[sec] <= work;
          xh2[sec] <= work;
          yh1[sec] <= prime_out;
          yh2[sec] <= prime_out;
          acc      <= '0;
          num      <= '0;
          den      <= DEN_ONE;
          k        <= '0;
          if (last_sec) begin
            primed <= 1'b1;
            sec    <= '0;
            work   <= samp_r;
            state  <= S_FMUL;
          end else begin
            sec   <= sec + SEC_W'(1);
            work  <= prime_out;
            state <= S_PSUM;
          end
        end
        S_FMUL: begin
          if (k == K_MAC_LAST) begin
            k     <= '0;
            state <= S_FDRAIN;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_FDRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= S_FRND;
          end
        end
        S_FRND: begin
          xh2[sec] <= xh1[sec];
          xh1[sec] <= work;
          yh2[sec] <= yh1[sec];
          yh1[sec] <= mac_out;
          work     <= mac_out;
          acc      <= '0;
          if (last_sec) begin
            sec   <= '0;
            state <= S_DONE;
          end else begin
            sec   <= sec + SEC_W'(1);
            state <= S_FMUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            filtered  <= sat_out(work);
            bypassed  <= byp;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
